// File: src/mvm_pkg.sv
package mvm_pkg;

   localparam int MAX_COLS   = 64;
   localparam int MAX_ROWS   = 64;
   localparam int DATA_WIDTH = 16;
   localparam int ACC_W      = 38;
   localparam int CNT_W      = 7;
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int WADDR_W    = COL_W + ROW_W;
   localparam int PROD_W     = 2 * DATA_WIDTH;

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 48;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 7;

   localparam logic [CNT_W-1:0] CNT_MAX      = '1;
   localparam logic [CNT_W-1:0] MAX_COLS_CNT = CNT_W'(MAX_COLS);
   localparam logic [CNT_W-1:0] MAX_ROWS_CNT = CNT_W'(MAX_ROWS);

   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_COLS = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_ROWS = 1'b1;

   localparam logic REQ_MATRIX = 1'b0;
   localparam logic REQ_VECTOR = 1'b1;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_MISMATCH = 1'b1;

   typedef logic signed [ACC_W-1:0] acc_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_DRAIN,
      ST_FINISH,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_EMIT_OUT
   } state_type;

   typedef struct packed {
      logic [ROW_W-1:0] rd_addr;
      logic             wr_en;
      logic [ROW_W-1:0] wr_addr;
      logic             clear_all;
   } acc_ctl_type;

endpackage

// File: src/mvm_acc_bank.sv
module mvm_acc_bank (
   input  logic                  clock,
   input  logic                  reset,
   input  mvm_pkg::acc_ctl_type  ctl,
   input  mvm_pkg::acc_type      wr_data,
   output mvm_pkg::acc_type      rd_data
);

   mvm_pkg::acc_type mem [mvm_pkg::MAX_ROWS];
   logic [mvm_pkg::MAX_ROWS-1:0] valid_ff;
   mvm_pkg::acc_type rd_q_ff;
   logic rd_vld_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= wr_data;
      end
      rd_q_ff <= mem[ctl.rd_addr];
      rd_vld_ff <= valid_ff[ctl.rd_addr];
   end

   // a row not written since the last clear reads as zero
   always_ff @(posedge clock) begin
      if (reset || ctl.clear_all) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[ctl.wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : '0;

endmodule

// File: src/matrix_vector_multiply.sv
// Column-major matrix by vector multiplier. Items with tuser 0 write one signed Q8.8
// weight at (col, row) into a 4096-entry weight RAM. Items with tuser 1 are vector
// elements in order; element k scales column k, one row per cycle through a
// read-multiply-add-write pipeline on the 64-entry accumulator RAM, and an element past
// num_cols is only counted. On the element with tlast the block streams one Q22.16 sum
// per row, or one mismatch result (tuser 1, zero sum) when the element count differs
// from num_cols or num_cols is zero, then clears the accumulators. One item is in
// flight at a time. Configure num_cols/num_rows only while idle; values above 64 act
// as 64. The element count is still checked against num_cols as written.
module matrix_vector_multiply (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mvm_pkg::REQ_TDATA_W-1:0]    req_tdata,  // col[5:0], row[11:6], value[27:12]
   input  logic                               req_tuser,  // req_type
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [mvm_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // row_sum[37:0], row_index[43:38]
   output logic                               rsp_tuser,  // status
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [mvm_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [mvm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   mvm_pkg::state_type state_ff, state_in;

   logic [mvm_pkg::CNT_W-1:0] num_cols_ff, num_rows_ff;
   logic [mvm_pkg::CNT_W-1:0] cols_eff, rows_eff;
   logic [mvm_pkg::CNT_W-1:0] ec_ff;

   logic [mvm_pkg::COL_W-1:0] req_col;
   logic [mvm_pkg::ROW_W-1:0] req_row;
   logic signed [mvm_pkg::DATA_WIDTH-1:0] req_value;

   logic signed [mvm_pkg::DATA_WIDTH-1:0] value_ff;
   logic last_ff;
   logic [mvm_pkg::COL_W-1:0] col_sel_ff;
   logic [mvm_pkg::ROW_W-1:0] iidx_ff, oidx_ff;

   logic s1_vld_ff, s2_vld_ff;
   logic [mvm_pkg::ROW_W-1:0] s1_idx_ff, s2_idx_ff;
   logic signed [mvm_pkg::PROD_W-1:0] prod_ff;
   mvm_pkg::acc_type accq_ff;

   logic signed [mvm_pkg::DATA_WIDTH-1:0] wmem [mvm_pkg::MAX_COLS * mvm_pkg::MAX_ROWS];
   logic signed [mvm_pkg::DATA_WIDTH-1:0] wq_ff;

   mvm_pkg::acc_type out_sum_ff;
   logic [mvm_pkg::ROW_W-1:0] out_idx_ff;
   logic out_status_ff, out_last_ff;

   mvm_pkg::acc_ctl_type acc_ctl;
   mvm_pkg::acc_type acc_wr_data, acc_rd_data;

   logic req_acc, rsp_acc;
   logic mismatch, iss_last, out_is_last, end_vec, will_acc;

   assign req_col   = req_tdata[mvm_pkg::COL_W-1:0];
   assign req_row   = req_tdata[mvm_pkg::COL_W +: mvm_pkg::ROW_W];
   assign req_value = req_tdata[12 +: mvm_pkg::DATA_WIDTH];

   assign cols_eff = (num_cols_ff > mvm_pkg::MAX_COLS_CNT) ? mvm_pkg::MAX_COLS_CNT : num_cols_ff;
   assign rows_eff = (num_rows_ff > mvm_pkg::MAX_ROWS_CNT) ? mvm_pkg::MAX_ROWS_CNT : num_rows_ff;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   assign mismatch    = (cols_eff == '0) || (ec_ff != num_cols_ff);
   assign iss_last    = ({1'b0, iidx_ff} == rows_eff - 1'b1);
   assign out_is_last = ({1'b0, oidx_ff} == rows_eff - 1'b1);
   assign will_acc    = (ec_ff < cols_eff) && (rows_eff != '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mvm_pkg::ST_IDLE: begin
            if (req_acc && req_tuser == mvm_pkg::REQ_VECTOR) begin
               state_in = will_acc ? mvm_pkg::ST_ACC : mvm_pkg::ST_FINISH;
            end
         end
         mvm_pkg::ST_ACC: begin
            if (iss_last) begin
               state_in = mvm_pkg::ST_DRAIN;
            end
         end
         mvm_pkg::ST_DRAIN: begin
            if (!s1_vld_ff && !s2_vld_ff) begin
               state_in = mvm_pkg::ST_FINISH;
            end
         end
         mvm_pkg::ST_FINISH: begin
            if (!last_ff) begin
               state_in = mvm_pkg::ST_IDLE;
            end else if (mismatch) begin
               state_in = mvm_pkg::ST_EMIT_OUT;
            end else if (rows_eff == '0) begin
               state_in = mvm_pkg::ST_IDLE;
            end else begin
               state_in = mvm_pkg::ST_EMIT_RD;
            end
         end
         mvm_pkg::ST_EMIT_RD:  state_in = mvm_pkg::ST_EMIT_LD;
         mvm_pkg::ST_EMIT_LD:  state_in = mvm_pkg::ST_EMIT_OUT;
         mvm_pkg::ST_EMIT_OUT: begin
            if (rsp_tready) begin
               state_in = out_last_ff ? mvm_pkg::ST_IDLE : mvm_pkg::ST_EMIT_RD;
            end
         end
         default: state_in = mvm_pkg::ST_IDLE;
      endcase
   end

   // outputs and accumulator bank control
   always_comb begin
      req_tready = (state_ff == mvm_pkg::ST_IDLE);
      rsp_tvalid = (state_ff == mvm_pkg::ST_EMIT_OUT);
      end_vec = (state_ff == mvm_pkg::ST_FINISH && last_ff && !mismatch && rows_eff == '0)
             || (rsp_acc && out_last_ff);
      acc_ctl.rd_addr   = (state_ff == mvm_pkg::ST_ACC) ? iidx_ff : oidx_ff;
      acc_ctl.wr_en     = s2_vld_ff;
      acc_ctl.wr_addr   = s2_idx_ff;
      acc_ctl.clear_all = end_vec;
   end

   assign acc_wr_data = accq_ff + mvm_pkg::acc_type'(prod_ff);

   mvm_acc_bank u_acc_bank (
      .clock   (clock),
      .reset   (reset),
      .ctl     (acc_ctl),
      .wr_data (acc_wr_data),
      .rd_data (acc_rd_data)
   );

   assign rsp_tdata = {{(mvm_pkg::RSP_TDATA_W - mvm_pkg::ACC_W - mvm_pkg::ROW_W){1'b0}},
                       out_idx_ff, out_sum_ff};
   assign rsp_tuser = out_status_ff;
   assign rsp_tlast = out_last_ff;

   // weight RAM
   always_ff @(posedge clock) begin
      if (req_acc && req_tuser == mvm_pkg::REQ_MATRIX
          && {1'b0, req_col} < mvm_pkg::MAX_COLS_CNT
          && {1'b0, req_row} < mvm_pkg::MAX_ROWS_CNT) begin
         wmem[{req_col, req_row}] <= req_value;
      end
      wq_ff <= wmem[{col_sel_ff, iidx_ff}];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= mvm_pkg::ST_IDLE;
         num_cols_ff <= mvm_pkg::MAX_COLS_CNT;
         num_rows_ff <= mvm_pkg::MAX_ROWS_CNT;
         ec_ff       <= '0;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         s1_vld_ff <= (state_ff == mvm_pkg::ST_ACC);
         s2_vld_ff <= s1_vld_ff;
         if (csr_we) begin
            case (csr_addr)
               mvm_pkg::CSR_NUM_COLS: num_cols_ff <= csr_wdata;
               mvm_pkg::CSR_NUM_ROWS: num_rows_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (end_vec) begin
            ec_ff <= '0;
         end else if (req_acc && req_tuser == mvm_pkg::REQ_VECTOR && ec_ff != mvm_pkg::CNT_MAX) begin
            ec_ff <= ec_ff + 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_acc && req_tuser == mvm_pkg::REQ_VECTOR) begin
         value_ff   <= req_value;
         last_ff    <= req_tlast;
         col_sel_ff <= ec_ff[mvm_pkg::COL_W-1:0];
         iidx_ff    <= '0;
      end else if (state_ff == mvm_pkg::ST_ACC) begin
         iidx_ff <= iidx_ff + 1'b1;
      end
      s1_idx_ff <= iidx_ff;
      s2_idx_ff <= s1_idx_ff;
      prod_ff   <= wq_ff * value_ff;
      accq_ff   <= acc_rd_data;

      case (state_ff)
         mvm_pkg::ST_FINISH: begin
            oidx_ff       <= '0;
            out_sum_ff    <= '0;
            out_idx_ff    <= '0;
            out_status_ff <= mvm_pkg::STATUS_MISMATCH;
            out_last_ff   <= 1'b1;
         end
         mvm_pkg::ST_EMIT_LD: begin
            out_sum_ff    <= acc_rd_data;
            out_idx_ff    <= oidx_ff;
            out_status_ff <= mvm_pkg::STATUS_OK;
            out_last_ff   <= out_is_last;
         end
         mvm_pkg::ST_EMIT_OUT: begin
            if (rsp_tready && !out_last_ff) begin
               oidx_ff <= oidx_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

`ifndef SYNTH
   // one item in flight: never taking a new item while a result is offered
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input accepted while result pending");

   // a mismatch result stands alone with a zero sum
   a_mismatch_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == mvm_pkg::STATUS_MISMATCH) |->
         (rsp_tlast && rsp_tdata == '0))
      else $error("malformed mismatch result");

   // element count restarts after the final result of a vector
   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_tlast) |=> (ec_ff == '0))
      else $error("element count not cleared");

   // read and write-back of the accumulator RAM never hit the same row
   a_no_rmw_clash: assert property (@(posedge clock) disable iff (reset)
      (s2_vld_ff && state_ff == mvm_pkg::ST_ACC) |-> (s2_idx_ff != iidx_ff))
      else $error("accumulator read/write collision");

   // the write-back pipeline is empty whenever a new item can be taken
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!s1_vld_ff && !s2_vld_ff))
      else $error("accumulate pipeline busy while idle");
`endif

endmodule

// File: tb/tb_matrix_vector_multiply.sv
`timescale 1ns / 100ps

module tb_matrix_vector_multiply;
   import mvm_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 100;
   localparam int RANDOM_ITEMS   = 50;

   typedef struct packed {
      acc_type          row_sum;
      logic [ROW_W-1:0] row_index;
      logic             status;
      logic             last_result;
   } row_result_t;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_TDATA_W-1:0]   req_tdata = '0;
   logic                     req_tuser = 1'b0;
   logic                     req_tlast = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;
   logic                     rsp_tuser;
   logic                     rsp_tlast;
   logic                     csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]    csr_addr = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   // shadow of the block
   logic signed [DATA_WIDTH-1:0] weight_mem [MAX_COLS*MAX_ROWS];
   bit                           weight_valid [MAX_COLS*MAX_ROWS];
   acc_type                      row_acc [MAX_ROWS];
   int                           elem_count;
   logic [CSR_DATA_W-1:0]        num_cols_q = CSR_DATA_W'(64);
   logic [CSR_DATA_W-1:0]        num_rows_q = CSR_DATA_W'(64);
   row_result_t                  expected_sums [$];

   bit tx_idle_on = 1'b1;
   bit rx_idle_on = 1'b1;
   bit hold_req   = 1'b0;
   int items_sent, vectors_sent, mismatch_vectors, results_seen, err_count, stall_cycles;

   matrix_vector_multiply dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // col[5:0], row[11:6], value[27:12]
      .req_tuser  (req_tuser),   // req_type
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // row_sum[37:0], row_index[43:38]
      .rsp_tuser  (rsp_tuser),   // status
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int eff_size(logic [CSR_DATA_W-1:0] raw, int cap);
      return (raw > cap) ? cap : int'(raw);
   endfunction

   // update the shadow with one accepted item, queue the sums it produces
   function automatic void apply_item(logic kind, logic [COL_W-1:0] col,
                                      logic [ROW_W-1:0] row,
                                      logic signed [DATA_WIDTH-1:0] value, logic last);
      int cols, rows, base;
      logic signed [PROD_W-1:0] prod;
      row_result_t res;
      cols = eff_size(num_cols_q, MAX_COLS);
      rows = eff_size(num_rows_q, MAX_ROWS);
      if (kind == REQ_MATRIX) begin
         weight_mem[col*MAX_ROWS + row] = value;
         weight_valid[col*MAX_ROWS + row] = 1'b1;
         return;
      end
      if (elem_count < cols) begin
         base = elem_count * MAX_ROWS;
         for (int i = 0; i < rows; i++) begin
            prod = weight_mem[base + i] * value;
            row_acc[i] = row_acc[i] + prod;
         end
      end
      if (elem_count < int'(CNT_MAX)) elem_count++;
      if (!last) return;
      vectors_sent++;
      if (cols == 0 || elem_count != int'(num_cols_q)) begin
         mismatch_vectors++;
         res = '{row_sum: '0, row_index: '0, status: STATUS_MISMATCH, last_result: 1'b1};
         expected_sums.insert(expected_sums.size(), res);
      end else begin
         for (int i = 0; i < rows; i++) begin
            res.row_sum     = row_acc[i];
            res.row_index   = ROW_W'(i);
            res.status      = STATUS_OK;
            res.last_result = (i == rows - 1);
            expected_sums.insert(expected_sums.size(), res);
         end
      end
      for (int i = 0; i < MAX_ROWS; i++) row_acc[i] = '0;
      elem_count = 0;
   endfunction

   function automatic logic [DATA_WIDTH-1:0] rand_value();
      case ($urandom_range(0, 7))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'hffff;
         3: return 16'h0000;
         default: return DATA_WIDTH'($urandom);
      endcase
   endfunction

   // drive one item at the falling edge, hold it until accepted
   task automatic send_item(logic kind, logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                            logic [DATA_WIDTH-1:0] value, logic last);
      int gap;
      gap = tx_idle_on ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tlast  <= last;
      req_tdata  <= {4'b0, value, row, col};
      do @(posedge clock); while (!req_tready);
      apply_item(kind, col, row, value, last);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_weight(int col, int row, logic [DATA_WIDTH-1:0] value);
      send_item(REQ_MATRIX, COL_W'(col), ROW_W'(row), value, 1'($urandom));
   endtask

   // vals empty: random elements; noisy: stray weight writes between elements
   task automatic send_vector(int len, logic [DATA_WIDTH-1:0] vals [$], bit noisy);
      logic [DATA_WIDTH-1:0] v;
      for (int k = 0; k < len; k++) begin
         if (noisy && $urandom_range(0, 7) == 0)
            send_weight($urandom_range(0, 63), $urandom_range(0, 63), rand_value());
         v = (k < vals.size()) ? vals[k] : rand_value();
         send_item(REQ_VECTOR, COL_W'($urandom), ROW_W'($urandom), v, k == len - 1);
      end
   endtask

   // registers change only with nothing in flight
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_sums.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      if (addr == CSR_NUM_COLS) num_cols_q = data;
      else num_rows_q = data;
      @(negedge clock);
   endtask

   // set sizes, then make sure every weight the vectors can read is written
   task automatic set_sizes(int cols, int rows);
      wait_idle();
      write_reg(CSR_NUM_COLS, CSR_DATA_W'(cols));
      write_reg(CSR_NUM_ROWS, CSR_DATA_W'(rows));
      for (int c = 0; c < eff_size(num_cols_q, MAX_COLS); c++)
         for (int r = 0; r < eff_size(num_rows_q, MAX_ROWS); r++)
            if (!weight_valid[c*MAX_ROWS + r]) send_weight(c, r, rand_value());
   endtask

   task automatic test_directed();
      logic [DATA_WIDTH-1:0] none [$];
      set_sizes(2, 2);
      send_weight(0, 0, 16'h7fff);
      send_weight(0, 1, 16'h8000);
      send_weight(1, 0, 16'h8000);
      send_weight(1, 1, 16'hffff);
      send_weight(63, 63, 16'h0001);
      send_item(REQ_MATRIX, 6'd63, 6'd0, 16'h8000, 1'b1);  // tlast on a write is ignored
      send_vector(2, '{16'h8000, 16'h8000}, 1'b0);
      send_vector(2, '{16'h7fff, 16'h0001}, 1'b0);
      send_vector(1, '{16'h7fff}, 1'b0);                   // short vector
      send_vector(3, '{16'h0100, 16'hff00, 16'h7fff}, 1'b0); // extra element
      set_sizes(0, 2);
      send_vector(1, '{16'h1234}, 1'b0);                   // zero columns
      set_sizes(2, 0);
      send_vector(2, '{16'h7fff, 16'h8000}, 1'b0);         // zero rows: no sums
      send_vector(2, none, 1'b0);
   endtask

   task automatic test_size_extremes();
      logic [DATA_WIDTH-1:0] none [$];
      for (int r = 0; r < MAX_ROWS; r++)
         send_weight(0, r, r[0] ? 16'h8000 : 16'h7fff);
      set_sizes(1, 64);
      send_vector(1, '{16'h8000}, 1'b0);
      send_vector(1, '{16'h7fff}, 1'b0);
      send_vector(2, none, 1'b0);
      set_sizes(1, 127);                  // rows above the maximum act as 64
      send_vector(1, none, 1'b0);
      set_sizes(64, 1);
      send_vector(64, none, 1'b0);
      set_sizes(127, 1);                  // element count saturates at 127
      send_vector(128, none, 1'b0);
      send_vector(3, none, 1'b0);
   endtask

   task automatic test_backpressure();
      logic [DATA_WIDTH-1:0] none [$];
      set_sizes(2, 16);
      hold_req = 1'b1;
      for (int n = 0; n < 6; n++) send_vector(2, none, 1'b0);
   endtask

   task automatic test_random();
      logic [DATA_WIDTH-1:0] none [$];
      int start, cols, rows, len;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: begin cols = 0;                      rows = $urandom_range(1, 8);  end
            1: begin cols = $urandom_range(9, 64);  rows = $urandom_range(1, 2);  end
            2: begin cols = $urandom_range(1, 6);   rows = 0;                     end
            3: begin cols = $urandom_range(1, 2);   rows = $urandom_range(9, 64); end
            4: begin cols = $urandom_range(65, 127); rows = 1;                    end
            default: begin cols = $urandom_range(1, 8); rows = $urandom_range(1, 8); end
         endcase
         set_sizes(cols, rows);
         tx_idle_on = ($urandom_range(0, 3) != 0);
         rx_idle_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(2, 5)) begin
            if ($urandom_range(0, 9) == 0) begin
               len = $urandom_range(1, cols + 3);
               if (len == cols) len++;
            end else begin
               len = (cols == 0) ? $urandom_range(1, 3) : cols;
            end
            send_vector(len, none, 1'b1);
         end
      end
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_size_extremes();
      test_backpressure();
      test_random();
      wait_idle();
      $display("Sent %0d items: %0d vectors, %0d of them with a size mismatch.",
               items_sent, vectors_sent, mismatch_vectors);
      $display("Checked %0d results, %0d mismatches.", results_seen, err_count);
      if (err_count == 0 && expected_sums.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   // result side: random stalls per item, one long hold-off on request
   initial begin : rsp_sink
      int wait_cycles;
      wait (!reset);
      @(negedge clock);
      forever begin
         wait_cycles = rx_idle_on ? $urandom_range(0, 15) : 0;
         if (hold_req) begin
            wait_cycles = HOLD_CYCLES;
            hold_req = 1'b0;
         end
         if (wait_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : rsp_check
      row_result_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[ACC_W-1:0], rsp_tdata[ACC_W+ROW_W-1:ACC_W], rsp_tuser, rsp_tlast};
         results_seen++;
         if (expected_sums.size() == 0) begin
            err_count++;
            if (err_count <= 10)
               $display("%0t: result with none expected: sum %0d row %0d status %0b last %0b",
                        $realtime, got.row_sum, got.row_index, got.status, got.last_result);
         end else begin
            want = expected_sums.pop_front();
            if (got !== want) begin
               err_count++;
               if (err_count <= 10) begin
                  $display("%0t: expected sum %0d row %0d status %0b last %0b", $realtime,
                           want.row_sum, want.row_index, want.status, want.last_result);
                  $display("%0t:   actual sum %0d row %0d status %0b last %0b", $realtime,
                           got.row_sum, got.row_index, got.status, got.last_result);
               end
            end
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("No item moved for %0d cycles, %0d results outstanding.",
                  stall_cycles, expected_sums.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

endmodule

// File: filelist.f
src/mvm_pkg.sv
src/mvm_acc_bank.sv
src/matrix_vector_multiply.sv
tb/tb_matrix_vector_multiply.sv
